>>> src/mtsx_pkg.sv
// Shared types, constants and byte helpers for the marker-tagged string patcher.
`timescale 1ns / 1ps

package mtsx_pkg;

   // Marker 2E 40 64 42 00 and the header that replaces it
   localparam logic [7:0] MARKER_START = 8'h2E;
   localparam logic [2:0] MARKER_LAST  = 3'd4;
   localparam logic [7:0] HEADER_BYTE  = 8'h21;
   localparam logic [7:0] STRING_END   = 8'h00;
   localparam logic [2:0] HEADER_LEN   = 3'd5;

   // Queue between the classifier and the byte emitter
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One unit of work for the emitter. A spill job gives prefix_count marker
   // bytes, then data when has_byte is set. A header job gives '!' and the key.
   typedef struct packed {
      logic        is_header;
      logic [2:0]  prefix_count;
      logic        has_byte;
      logic [7:0]  data;
      logic [31:0] key;
      logic        eos;
   } job_type;

   // Byte of the marker at a position (0..4)
   function automatic logic [7:0] marker_byte(input logic [2:0] pos);
      logic [7:0] value;
      case (pos)
         3'd0:    value = 8'h2E;
         3'd1:    value = 8'h40;
         3'd2:    value = 8'h64;
         3'd3:    value = 8'h42;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

   // Key byte, least significant first
   function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
      logic [7:0] value;
      case (idx)
         2'd0:    value = key[7:0];
         2'd1:    value = key[15:8];
         2'd2:    value = key[23:16];
         default: value = key[31:24];
      endcase
      return value;
   endfunction

endpackage

>>> src/mtsx_front.sv
// Front end: accepts requests, tracks marker matching and string state, issues jobs.
`timescale 1ns / 1ps

module mtsx_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic [31:0]          req_string_key,
   input  logic                 req_end_of_stream,
   input  logic                 push_ready,
   output logic                 push_valid,
   output mtsx_pkg::job_type    push_job
);

   logic [2:0]  held_count_ff, held_count_in;
   logic        in_string_ff, in_string_in;
   logic [31:0] active_key_ff, active_key_in;
   logic [1:0]  key_index_ff, key_index_in;
   logic        accept;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;

   // Classify the request and build its job
   always_comb begin
      held_count_in = held_count_ff;
      in_string_in  = in_string_ff;
      active_key_in = active_key_ff;
      key_index_in  = key_index_ff;
      push_job      = '0;
      push_job.eos  = req_end_of_stream;
      if (accept) begin
         if (in_string_ff) begin
            // Scramble one string byte; the terminator ends the string
            push_job.has_byte = 1'b1;
            push_job.data     = req_data_byte ^ mtsx_pkg::key_byte(active_key_ff, key_index_ff);
            key_index_in      = key_index_ff + 2'd1;
            if (req_data_byte == mtsx_pkg::STRING_END) begin
               in_string_in = 1'b0;
            end
         end else if (req_data_byte == mtsx_pkg::marker_byte(held_count_ff)) begin
            if (held_count_ff == mtsx_pkg::MARKER_LAST) begin
               // Marker complete: emit header, start the string
               push_job.is_header = 1'b1;
               push_job.key       = req_string_key;
               held_count_in      = 3'd0;
               active_key_in      = req_string_key;
               key_index_in       = 2'd0;
               in_string_in       = 1'b1;
            end else begin
               // Hold one more prefix byte; spill it all at end of stream
               held_count_in = held_count_ff + 3'd1;
               if (req_end_of_stream) begin
                  push_job.prefix_count = held_count_ff + 3'd1;
               end
            end
         end else begin
            // Match broken: spill held bytes, then hold or pass the new one
            push_job.prefix_count = held_count_ff;
            if (req_data_byte == mtsx_pkg::MARKER_START && !req_end_of_stream) begin
               held_count_in = 3'd1;
            end else begin
               push_job.has_byte = 1'b1;
               push_job.data     = req_data_byte;
               held_count_in     = 3'd0;
            end
         end
         // End of stream returns to the starting state
         if (req_end_of_stream) begin
            held_count_in = 3'd0;
            in_string_in  = 1'b0;
            active_key_in = 32'd0;
            key_index_in  = 2'd0;
         end
      end
   end

   assign push_valid = accept &&
      (push_job.is_header || push_job.has_byte || (push_job.prefix_count != 3'd0));

   // Hold matching and string state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 3'd0;
         in_string_ff  <= 1'b0;
         active_key_ff <= 32'd0;
         key_index_ff  <= 2'd0;
      end else begin
         held_count_ff <= held_count_in;
         in_string_ff  <= in_string_in;
         active_key_ff <= active_key_in;
         key_index_ff  <= key_index_in;
      end
   end

   a_held_range: assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= mtsx_pkg::MARKER_LAST)
      else $error("held count beyond marker prefix length");

   a_string_no_held: assert property (@(posedge clock) disable iff (reset)
      in_string_ff |-> (held_count_ff == 3'd0))
      else $error("bytes held while inside a string");

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_stream) |=> (held_count_ff == 3'd0 && !in_string_ff))
      else $error("state not cleared after end of stream");

endmodule

>>> src/mtsx_queue.sv
// Short job queue between the front end and the emitter.
`timescale 1ns / 1ps

module mtsx_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  mtsx_pkg::job_type push_job,
   output logic              push_ready,
   input  logic              pop,
   output logic              head_valid,
   output mtsx_pkg::job_type head_job
);

   mtsx_pkg::job_type                     slots_ff [mtsx_pkg::QUEUE_DEPTH];
   logic [mtsx_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [mtsx_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [mtsx_pkg::QUEUE_CNT_W-1:0]      count_ff, count_in;
   logic                                  do_push, do_pop;

   assign push_ready = (count_ff != mtsx_pkg::QUEUE_CNT_W'(mtsx_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + mtsx_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + mtsx_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + mtsx_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - mtsx_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> src/mtsx_back.sv
// Emitter: expands queued jobs into result bytes through an output register.
`timescale 1ns / 1ps

module mtsx_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  mtsx_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last_of_run,
   output logic              rsp_stream_done
);

   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_out_byte_ff, rsp_out_byte_in;
   logic       rsp_last_of_run_ff, rsp_last_of_run_in;
   logic       rsp_stream_done_ff, rsp_stream_done_in;
   logic [2:0] total, last_idx;
   logic [7:0] cur_byte;
   logic       final_byte, emit;

   // Pick the byte at the current position of the head job
   always_comb begin
      if (head_job.is_header) begin
         total = mtsx_pkg::HEADER_LEN;
         if (idx_ff == 3'd0) begin
            cur_byte = mtsx_pkg::HEADER_BYTE;
         end else begin
            cur_byte = mtsx_pkg::key_byte(head_job.key, 2'(idx_ff - 3'd1));
         end
      end else begin
         total = head_job.prefix_count + {2'b00, head_job.has_byte};
         if (idx_ff < head_job.prefix_count) begin
            cur_byte = mtsx_pkg::marker_byte(idx_ff);
         end else begin
            cur_byte = head_job.data;
         end
      end
   end

   assign last_idx   = total - 3'd1;
   assign final_byte = (idx_ff == last_idx);
   assign emit       = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop        = emit && final_byte;

   // Load the output register and step through the job
   always_comb begin
      idx_in             = idx_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_out_byte_in    = rsp_out_byte_ff;
      rsp_last_of_run_in = rsp_last_of_run_ff;
      rsp_stream_done_in = rsp_stream_done_ff;
      if (emit) begin
         rsp_valid_in       = 1'b1;
         rsp_out_byte_in    = cur_byte;
         rsp_last_of_run_in = final_byte;
         rsp_stream_done_in = final_byte && head_job.eos;
         idx_in             = final_byte ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_out_byte_ff    <= rsp_out_byte_in;
      rsp_last_of_run_ff <= rsp_last_of_run_in;
      rsp_stream_done_ff <= rsp_stream_done_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_out_byte_ff;
   assign rsp_last_of_run = rsp_last_of_run_ff;
   assign rsp_stream_done = rsp_stream_done_ff;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stream_done_ff) |-> rsp_last_of_run_ff)
      else $error("stream done without last of run");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= mtsx_pkg::MARKER_LAST)
      else $error("emit position beyond five bytes");

   a_job_held: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 3'd0) |-> head_valid)
      else $error("job left the queue while partly emitted");

endmodule

>>> src/marker_tagged_string_xor_patcher.sv
// Top level of the marker-tagged string patcher: front end, job queue, emitter.
//
//   channel   direction  ports
//   req       in         req_valid/req_ready, data_byte, string_key, end_of_stream
//   rsp       out        rsp_valid/rsp_ready, out_byte, last_of_run, stream_done
//
// A request is taken every cycle while the four-entry job queue has room; the
// emitter gives one result byte per cycle unless rsp_ready stalls it, so a completed
// marker occupies it for its five header bytes and the queue absorbs the burst. A job
// is stored in a queue slot, then its bytes pass the emitter's output register. Reset
// clears match state, queue and output register.
// Either side may stall without losing or repeating a byte.
`timescale 1ns / 1ps

module marker_tagged_string_xor_patcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic [31:0] req_string_key,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_stream_done
);

   logic              push_valid, push_ready, head_valid, pop;
   mtsx_pkg::job_type push_job, head_job;

   mtsx_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_string_key    (req_string_key),
      .req_end_of_stream (req_end_of_stream),
      .push_ready        (push_ready),
      .push_valid        (push_valid),
      .push_job          (push_job)
   );

   mtsx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   mtsx_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_stream_done (rsp_stream_done)
   );

endmodule
